// ===== src/frt_pkg.sv =====
// shared types, constants and the arctangent table of the follower trajectory block
// no dependencies
package frt_pkg;

	localparam int unsigned DataW          = 32;
	localparam int unsigned InDataW        = 6 * DataW;
	localparam int unsigned OutDataW       = 8 * DataW;
	localparam int unsigned CordicStepsDef = 16;
	localparam int unsigned CntW           = 6;
	localparam int unsigned ModBits        = 14;
	localparam int unsigned SqrtSteps      = 32;
	localparam int unsigned DivBits        = 33;

	localparam logic        [32:0] TwoPiQ30  = 33'd6746518852;
	localparam logic signed [34:0] TwoPiS    = 35'sd6746518852;
	localparam logic signed [34:0] PiQ30     = 35'sd3373259426;
	localparam logic signed [34:0] HalfPiQ30 = 35'sd1686629713;
	localparam logic signed [33:0] GainQ30   = 34'sd652032874;

	typedef enum logic [4:0] {
		OP_NONE, OP_LOAD, OP_MOD, OP_FOLD, OP_ROT, OP_MULC, OP_MULS, OP_POSY,
		OP_DIFF, OP_SQX, OP_SQY, OP_SUM, OP_SQRT, OP_DIVLD, OP_DIV, OP_DIVWR,
		OP_EMITP, OP_EMITF, OP_UPD
	} dp_op_t;

	typedef struct packed {
		dp_op_t          op;
		logic [CntW-1:0] step;
		logic [1:0]      sel;
	} dp_cmd_t;

	typedef struct packed {
		logic have_prev;
		logic fin;
		logic slot_free;
	} dp_stat_t;

	function automatic logic [31:0] atan_q30(input logic [4:0] i);
		logic [31:0] r;
		case (i)
			5'd0:  r = 32'h3243F6A8;
			5'd1:  r = 32'h1DAC6705;
			5'd2:  r = 32'h0FADBAFC;
			5'd3:  r = 32'h07F56EA6;
			5'd4:  r = 32'h03FEAB76;
			5'd5:  r = 32'h01FFD55B;
			5'd6:  r = 32'h00FFFAAA;
			5'd7:  r = 32'h007FFF55;
			5'd8:  r = 32'h003FFFEA;
			5'd9:  r = 32'h001FFFFD;
			5'd10: r = 32'h000FFFFF;
			5'd11: r = 32'h0007FFFF;
			5'd12: r = 32'h0003FFFF;
			5'd13: r = 32'h0001FFFF;
			5'd14: r = 32'h0000FFFF;
			5'd15: r = 32'h00007FFF;
			5'd16: r = 32'h00003FFF;
			5'd17: r = 32'h00001FFF;
			5'd18: r = 32'h00000FFF;
			5'd19: r = 32'h000007FF;
			5'd20: r = 32'h000003FF;
			5'd21: r = 32'h000001FF;
			5'd22: r = 32'h000000FF;
			5'd23: r = 32'h0000007F;
			5'd24: r = 32'h0000003F;
			5'd25: r = 32'h0000001F;
			5'd26: r = 32'h0000000F;
			5'd27: r = 32'h00000008;
			5'd28: r = 32'h00000004;
			5'd29: r = 32'h00000002;
			5'd30: r = 32'h00000001;
			default: r = 32'h00000000;
		endcase
		return r;
	endfunction

endpackage

// ===== src/frt_ctrl.sv =====
// sequencing state machine of the follower trajectory block
// depends on frt_pkg
module frt_ctrl #(
	parameter int unsigned CORDIC_STEPS = frt_pkg::CordicStepsDef
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	output logic               s_tready,
	input  frt_pkg::dp_stat_t  stat,
	output frt_pkg::dp_cmd_t   cmd
);

	typedef enum logic [17:0] {
		S_IDLE  = 18'd1,
		S_MOD   = 18'd2,
		S_FOLD  = 18'd4,
		S_ROT   = 18'd8,
		S_MULC  = 18'd16,
		S_MULS  = 18'd32,
		S_POSY  = 18'd64,
		S_DIFF  = 18'd128,
		S_SQX   = 18'd256,
		S_SQY   = 18'd512,
		S_SUM   = 18'd1024,
		S_SQRT  = 18'd2048,
		S_DIVLD = 18'd4096,
		S_DIV   = 18'd8192,
		S_DIVWR = 18'd16384,
		S_EMITP = 18'd32768,
		S_EMITF = 18'd65536,
		S_UPD   = 18'd131072
	} state_t;

	localparam logic [frt_pkg::CntW-1:0] RotLast  = frt_pkg::CntW'(CORDIC_STEPS - 1);
	localparam logic [frt_pkg::CntW-1:0] ModLast  = frt_pkg::CntW'(frt_pkg::ModBits - 1);
	localparam logic [frt_pkg::CntW-1:0] SqrtLast = frt_pkg::CntW'(frt_pkg::SqrtSteps - 1);
	localparam logic [frt_pkg::CntW-1:0] DivLast  = frt_pkg::CntW'(frt_pkg::DivBits - 1);

	state_t                    state_q, state_d;
	logic [frt_pkg::CntW-1:0]  cnt_q, cnt_d;
	logic [1:0]                sel_q, sel_d;

	always_comb begin
		state_d  = state_q;
		cnt_d    = cnt_q;
		sel_d    = sel_q;
		s_tready = 1'b0;
		cmd.op   = frt_pkg::OP_NONE;
		cmd.step = cnt_q;
		cmd.sel  = sel_q;
		case (state_q)
			S_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.op  = frt_pkg::OP_LOAD;
					cnt_d   = ModLast;
					state_d = S_MOD;
				end
			end
			S_MOD: begin
				cmd.op = frt_pkg::OP_MOD;
				if (cnt_q == '0) begin
					state_d = S_FOLD;
				end else begin
					cnt_d = cnt_q - 1'b1;
				end
			end
			S_FOLD: begin
				cmd.op  = frt_pkg::OP_FOLD;
				cnt_d   = '0;
				state_d = S_ROT;
			end
			S_ROT: begin
				cmd.op = frt_pkg::OP_ROT;
				if (cnt_q == RotLast) begin
					state_d = S_MULC;
				end else begin
					cnt_d = cnt_q + 1'b1;
				end
			end
			S_MULC: begin
				cmd.op  = frt_pkg::OP_MULC;
				state_d = S_MULS;
			end
			S_MULS: begin
				cmd.op  = frt_pkg::OP_MULS;
				state_d = S_POSY;
			end
			S_POSY: begin
				cmd.op = frt_pkg::OP_POSY;
				if (stat.have_prev) begin
					state_d = S_DIFF;
				end else if (stat.fin) begin
					state_d = S_EMITF;
				end else begin
					state_d = S_UPD;
				end
			end
			S_DIFF: begin
				cmd.op  = frt_pkg::OP_DIFF;
				state_d = S_SQX;
			end
			S_SQX: begin
				cmd.op  = frt_pkg::OP_SQX;
				state_d = S_SQY;
			end
			S_SQY: begin
				cmd.op  = frt_pkg::OP_SQY;
				state_d = S_SUM;
			end
			S_SUM: begin
				cmd.op  = frt_pkg::OP_SUM;
				cnt_d   = '0;
				state_d = S_SQRT;
			end
			S_SQRT: begin
				cmd.op = frt_pkg::OP_SQRT;
				if (cnt_q == SqrtLast) begin
					sel_d   = '0;
					state_d = S_DIVLD;
				end else begin
					cnt_d = cnt_q + 1'b1;
				end
			end
			S_DIVLD: begin
				cmd.op  = frt_pkg::OP_DIVLD;
				cnt_d   = DivLast;
				state_d = S_DIV;
			end
			S_DIV: begin
				cmd.op = frt_pkg::OP_DIV;
				if (cnt_q == '0) begin
					state_d = S_DIVWR;
				end else begin
					cnt_d = cnt_q - 1'b1;
				end
			end
			S_DIVWR: begin
				cmd.op = frt_pkg::OP_DIVWR;
				if (sel_q == 2'd3) begin
					state_d = S_EMITP;
				end else begin
					sel_d   = sel_q + 1'b1;
					state_d = S_DIVLD;
				end
			end
			S_EMITP: begin
				if (stat.slot_free) begin
					cmd.op  = frt_pkg::OP_EMITP;
					state_d = stat.fin ? S_EMITF : S_UPD;
				end
			end
			S_EMITF: begin
				if (stat.slot_free) begin
					cmd.op  = frt_pkg::OP_EMITF;
					state_d = S_UPD;
				end
			end
			S_UPD: begin
				cmd.op  = frt_pkg::OP_UPD;
				state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
			sel_q   <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			sel_q   <= sel_d;
		end
	end

endmodule

// ===== src/frt_dp.sv =====
// datapath: angle reduction, cordic, shared multiplier, square root, divider, output register
// depends on frt_pkg
module frt_dp (
	input  logic                          clk,
	input  logic                          arst_n,
	input  frt_pkg::dp_cmd_t              cmd,
	output frt_pkg::dp_stat_t             stat,
	input  logic [frt_pkg::InDataW-1:0]   s_tdata,
	input  logic                          s_tlast,
	input  logic signed [31:0]            follow_offset,
	input  logic signed [31:0]            follow_angle,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [frt_pkg::OutDataW-1:0]  m_tdata,
	output logic                          m_tlast
);

	function automatic logic [31:0] sat32(input logic signed [38:0] v);
		logic [31:0] r;
		if (v > 39'sd2147483647) begin
			r = 32'h7FFFFFFF;
		end else if (v < -39'sd2147483648) begin
			r = 32'h80000000;
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

	logic signed [31:0] lx_q, ly_q, lh_q, ls_q, lw_q, lt_q;
	logic               fin_q;
	logic [46:0]        rem_q;
	logic               ang_neg_q;
	logic signed [34:0] z_q;
	logic signed [33:0] x_q, y_q;
	logic               neg_q;
	logic signed [67:0] mul_q;
	logic signed [31:0] fx_q, fy_q;
	logic [31:0]        ax_q, ay_q;
	logic               big_q;
	logic [63:0]        acc_q, sv_q, root_q, bit_q;
	logic [49:0]        nrem_q;
	logic [64:0]        dsh_q;
	logic [32:0]        quo_q;
	logic               ovf_q, nzero_q, nsign_q, dzero_q, dsign_q;
	logic signed [31:0] sp_q, tr_q, ta_q, ac_q;
	logic signed [31:0] pfx_q, pfy_q, ph_q, ps_q, pw_q, pt_q;
	logic               have_q;
	logic               out_valid_q, out_last_q;
	logic [frt_pkg::OutDataW-1:0] out_data_q;

	logic signed [32:0] ang;
	logic [32:0]        ang_mag;
	logic [46:0]        csh;
	logic signed [34:0] r0, r1, r2;
	logic               fold_neg;
	logic signed [33:0] xs, ys, cval, sval, off_ext, mul_a, mul_b;
	logic signed [34:0] at;
	logic signed [67:0] rnd;
	logic signed [38:0] sum_x, sum_y;
	logic signed [32:0] dx, dy, dt;
	logic [32:0]        adx, ady;
	logic               big;
	logic [63:0]        sq_t;
	logic [33:0]        ds;
	logic signed [33:0] num;
	logic [33:0]        nmag;
	logic [32:0]        dmag;
	logic [31:0]        qres;

	assign ang     = 33'($signed(s_tdata[95:64])) - 33'(follow_angle);
	assign ang_mag = ang[32] ? 33'(-ang) : 33'(ang);

	assign csh = {14'b0, frt_pkg::TwoPiQ30} << cmd.step[3:0];

	always_comb begin
		r0 = $signed({2'b00, rem_q[32:0]});
		if (ang_neg_q) begin
			r0 = -r0;
		end
		if (r0 > frt_pkg::PiQ30) begin
			r1 = r0 - frt_pkg::TwoPiS;
		end else if (r0 < -frt_pkg::PiQ30) begin
			r1 = r0 + frt_pkg::TwoPiS;
		end else begin
			r1 = r0;
		end
		fold_neg = 1'b0;
		if (r1 > frt_pkg::HalfPiQ30) begin
			r2       = r1 - frt_pkg::PiQ30;
			fold_neg = 1'b1;
		end else if (r1 < -frt_pkg::HalfPiQ30) begin
			r2       = r1 + frt_pkg::PiQ30;
			fold_neg = 1'b1;
		end else begin
			r2 = r1;
		end
	end

	assign xs      = x_q >>> cmd.step[4:0];
	assign ys      = y_q >>> cmd.step[4:0];
	assign at      = $signed({3'b000, frt_pkg::atan_q30(cmd.step[4:0])});
	assign cval    = neg_q ? -x_q : x_q;
	assign sval    = neg_q ? -y_q : y_q;
	assign off_ext = 34'(follow_offset);

	always_comb begin
		mul_a = off_ext;
		mul_b = cval;
		case (cmd.op)
			frt_pkg::OP_MULS: begin
				mul_b = sval;
			end
			frt_pkg::OP_SQX: begin
				mul_a = $signed({2'b00, ax_q});
				mul_b = $signed({2'b00, ax_q});
			end
			frt_pkg::OP_SQY: begin
				mul_a = $signed({2'b00, ay_q});
				mul_b = $signed({2'b00, ay_q});
			end
			default: begin
				mul_b = cval;
			end
		endcase
	end

	assign rnd   = (mul_q + 68'sd536870912) >>> 30;
	assign sum_x = 39'(lx_q) + $signed(rnd[38:0]);
	assign sum_y = 39'(ly_q) + $signed(rnd[38:0]);

	assign dx  = 33'(fx_q) - 33'(pfx_q);
	assign dy  = 33'(fy_q) - 33'(pfy_q);
	assign adx = dx[32] ? 33'(-dx) : 33'(dx);
	assign ady = dy[32] ? 33'(-dy) : 33'(dy);
	assign big = adx[32] | adx[31] | ady[32] | ady[31];

	assign sq_t = root_q + bit_q;
	assign ds   = big_q ? {root_q[32:0], 1'b0} : {1'b0, root_q[32:0]};
	assign dt   = 33'(lt_q) - 33'(pt_q);

	always_comb begin
		case (cmd.sel)
			2'd0:    num = $signed(ds);
			2'd1:    num = 34'(33'(lh_q) - 33'(ph_q));
			2'd2:    num = 34'(33'(lw_q) - 33'(pw_q));
			default: num = 34'(33'(ls_q) - 33'(ps_q));
		endcase
	end

	assign nmag = num[33] ? 34'(-num) : 34'(num);
	assign dmag = dt[32] ? 33'(-dt) : 33'(dt);

	always_comb begin
		if (dzero_q) begin
			if (nzero_q) begin
				qres = 32'h00000000;
			end else begin
				qres = nsign_q ? 32'h80000000 : 32'h7FFFFFFF;
			end
		end else if (nsign_q ^ dsign_q) begin
			if (ovf_q || quo_q > 33'h080000000) begin
				qres = 32'h80000000;
			end else begin
				qres = 32'(-quo_q);
			end
		end else begin
			if (ovf_q || quo_q[32] || quo_q[31]) begin
				qres = 32'h7FFFFFFF;
			end else begin
				qres = quo_q[31:0];
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		case (cmd.op)
			frt_pkg::OP_LOAD: begin
				lx_q      <= s_tdata[31:0];
				ly_q      <= s_tdata[63:32];
				lh_q      <= s_tdata[95:64];
				ls_q      <= s_tdata[127:96];
				lw_q      <= s_tdata[159:128];
				lt_q      <= s_tdata[191:160];
				fin_q     <= s_tlast;
				rem_q     <= {ang_mag, 14'b0};
				ang_neg_q <= ang[32];
			end
			frt_pkg::OP_MOD: begin
				if (rem_q >= csh) begin
					rem_q <= rem_q - csh;
				end
			end
			frt_pkg::OP_FOLD: begin
				z_q   <= r2;
				neg_q <= fold_neg;
				x_q   <= frt_pkg::GainQ30;
				y_q   <= '0;
			end
			frt_pkg::OP_ROT: begin
				if (z_q >= 0) begin
					x_q <= x_q - ys;
					y_q <= y_q + xs;
					z_q <= z_q - at;
				end else begin
					x_q <= x_q + ys;
					y_q <= y_q - xs;
					z_q <= z_q + at;
				end
			end
			frt_pkg::OP_MULC: begin
				mul_q <= mul_a * mul_b;
			end
			frt_pkg::OP_MULS: begin
				fx_q  <= sat32(sum_x);
				mul_q <= mul_a * mul_b;
			end
			frt_pkg::OP_POSY: begin
				fy_q <= sat32(sum_y);
			end
			frt_pkg::OP_DIFF: begin
				big_q <= big;
				ax_q  <= big ? adx[32:1] : adx[31:0];
				ay_q  <= big ? ady[32:1] : ady[31:0];
			end
			frt_pkg::OP_SQX: begin
				mul_q <= mul_a * mul_b;
			end
			frt_pkg::OP_SQY: begin
				acc_q <= mul_q[63:0];
				mul_q <= mul_a * mul_b;
			end
			frt_pkg::OP_SUM: begin
				sv_q   <= acc_q + mul_q[63:0];
				root_q <= '0;
				bit_q  <= 64'h4000_0000_0000_0000;
			end
			frt_pkg::OP_SQRT: begin
				if (sv_q >= sq_t) begin
					sv_q   <= sv_q - sq_t;
					root_q <= (root_q >> 1) + bit_q;
				end else begin
					root_q <= root_q >> 1;
				end
				bit_q <= bit_q >> 2;
			end
			frt_pkg::OP_DIVLD: begin
				nrem_q  <= {nmag, 16'b0};
				dsh_q   <= {dmag, 32'b0};
				quo_q   <= '0;
				ovf_q   <= {16'b0, nmag[33:17]} >= dmag;
				nzero_q <= (num == '0);
				nsign_q <= num[33];
				dzero_q <= (dt == '0);
				dsign_q <= dt[32];
			end
			frt_pkg::OP_DIV: begin
				if ({15'b0, nrem_q} >= dsh_q) begin
					nrem_q <= nrem_q - dsh_q[49:0];
					quo_q  <= {quo_q[31:0], 1'b1};
				end else begin
					quo_q  <= {quo_q[31:0], 1'b0};
				end
				dsh_q <= dsh_q >> 1;
			end
			frt_pkg::OP_DIVWR: begin
				case (cmd.sel)
					2'd0:    sp_q <= qres;
					2'd1:    tr_q <= qres;
					2'd2:    ta_q <= qres;
					default: ac_q <= qres;
				endcase
			end
			frt_pkg::OP_EMITP: begin
				out_data_q <= {pt_q, ac_q, ta_q, tr_q, sp_q, ph_q, pfy_q, pfx_q};
				out_last_q <= 1'b0;
			end
			frt_pkg::OP_EMITF: begin
				out_data_q <= {lt_q, 32'd0, 32'd0, 32'd0, 32'd0, have_q ? ph_q : lh_q,
					fy_q, fx_q};
				out_last_q <= 1'b1;
			end
			frt_pkg::OP_UPD: begin
				if (!fin_q) begin
					pfx_q <= fx_q;
					pfy_q <= fy_q;
					ph_q  <= lh_q;
					ps_q  <= ls_q;
					pw_q  <= lw_q;
					pt_q  <= lt_q;
				end
			end
			default: begin
				quo_q <= quo_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			have_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.op == frt_pkg::OP_UPD) begin
				have_q <= !fin_q;
			end
			if (cmd.op == frt_pkg::OP_EMITP || cmd.op == frt_pkg::OP_EMITF) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign stat.have_prev = have_q;
	assign stat.fin       = fin_q;
	assign stat.slot_free = !out_valid_q || m_tready;

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tlast  = out_last_q;

endmodule

// ===== src/follower_reference_trajectory_top.sv =====
// top level of the follower reference trajectory generator: register port and stream ports
// depends on frt_pkg, frt_ctrl and frt_dp
//
//  channel  direction  handshake            payload
//  s_       in         s_tvalid / s_tready  s_tdata leader point, s_tlast final point
//  m_       out        m_tvalid / m_tready  m_tdata follower point, m_tlast last point
//  apb      in         psel, penable        follow_offset at 0x0, follow_angle at 0x4
//
// an item passes angle reduction of 14 steps and the cordic at one step a cycle; with a held
// point it also takes the square root of 32 steps and four divisions, and a final point adds
// a final emission
// s_tready is high only while the sequencer is idle; a waiting result does not block it
// a full output register stalls the sequencer at emission until m_tready
// reset clears the held-point flag, the output valid and both registers
module follower_reference_trajectory_top #(
	parameter int unsigned CORDIC_STEPS = frt_pkg::CordicStepsDef
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	// lead_x, lead_y, lead_heading, lead_speed, lead_turn_rate, lead_time
	input  logic [frt_pkg::InDataW-1:0]   s_tdata,
	input  logic                          s_tlast,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// pos_x, pos_y, heading, speed, turn_rate, turn_accel, accel, time_stamp
	output logic [frt_pkg::OutDataW-1:0]  m_tdata,
	output logic                          m_tlast,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [2:0]                    paddr,
	input  logic [31:0]                   pwdata,
	output logic [31:0]                   prdata,
	output logic                          pready
);

	localparam logic RegOffset = 1'b0;
	localparam logic RegAngle  = 1'b1;

	logic signed [31:0] offset_q, angle_q;
	frt_pkg::dp_cmd_t   cmd;
	frt_pkg::dp_stat_t  stat;

	assign pready = 1'b1;
	assign prdata = (paddr[2] == RegAngle) ? angle_q : offset_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_q <= '0;
			angle_q  <= '0;
		end else if (psel && penable && pwrite) begin
			if (paddr[2] == RegOffset) begin
				offset_q <= pwdata;
			end else begin
				angle_q <= pwdata;
			end
		end
	end

	frt_ctrl #(
		.CORDIC_STEPS(CORDIC_STEPS)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	frt_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.stat          (stat),
		.s_tdata       (s_tdata),
		.s_tlast       (s_tlast),
		.follow_offset (offset_q),
		.follow_angle  (angle_q),
		.m_tvalid      (m_tvalid),
		.m_tready      (m_tready),
		.m_tdata       (m_tdata),
		.m_tlast       (m_tlast)
	);

endmodule

// ===== src/frt_chk.sv =====
// port-level checks of the follower trajectory block, bound to the top level
// depends on frt_pkg and follower_reference_trajectory_top
module frt_chk (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          s_tvalid,
	input logic                          s_tready,
	input logic                          m_tvalid,
	input logic                          m_tready,
	input logic [frt_pkg::OutDataW-1:0]  m_tdata,
	input logic                          m_tlast,
	input logic                          psel,
	input logic                          penable,
	input logic                          pwrite,
	input logic [2:0]                    paddr,
	input logic [31:0]                   pwdata,
	input logic [31:0]                   prdata,
	input logic                          pready
);

	// a stalled result stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("result dropped while stalled");

	// a stalled result keeps its payload
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tlast))
		else $error("result payload changed while stalled");

	// one transaction at a time on the input side
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input taken while an item is in work");

	// a register read straight after a write returns the written value
	a_cfg_readback: assert property (@(posedge clk) disable iff (!arst_n)
		(psel && penable && pwrite && pready) ##1 (psel && !pwrite && paddr[2] == $past(paddr[2]))
		|-> prdata == $past(pwdata))
		else $error("register read-back mismatch");

endmodule

bind follower_reference_trajectory_top frt_chk u_frt_chk (.*);
